FILE: design/spzr_pkg.sv
// ----------------------------------------------------------------------------
// spzr_pkg
// Shared types and constants for the spectrum zero-run encoder.
// ----------------------------------------------------------------------------
package spzr_pkg;

    // Field widths
    localparam int PIXEL_W = 24;
    localparam int WORD_W  = 16;
    localparam int CNT_W   = 5;   // holds PIXEL_W, the divider step count

    // Special words
    localparam logic [WORD_W-1:0] RUN_FLAG        = 16'hFFFF;
    localparam logic [WORD_W-1:0] END_WORD        = 16'hFFFF;
    localparam logic [WORD_W-1:0] RUN_LIMIT       = 16'hFFFE;
    localparam logic [WORD_W-1:0] MIN_FLAGGED_RUN = 16'd3;

    // Register map (word index)
    localparam logic REG_LINE_WIDTH = 1'b0;

    // Word source for the output register
    typedef enum logic [3:0] {
        SEL_X_LO,
        SEL_X_HI,
        SEL_Y_LO,
        SEL_Y_HI,
        SEL_ZERO,
        SEL_FLAG,
        SEL_RUN,
        SEL_COUNT,
        SEL_END,
        SEL_END_LAST
    } word_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic      capture;
        logic      load_out;
        word_sel_t sel;
    } spzr_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic first;
        logic last;
        logic count_zero;
        logic limit_hit;
        logic run_ge3;
        logic run_two;
        logic run_one;
        logic div_busy;
        logic out_free;
    } spzr_stat_t;

endpackage

FILE: design/spzr_div.sv
// ----------------------------------------------------------------------------
// spzr_div
// Restoring divider, one quotient bit per cycle: splits a pixel number into
// line (quotient) and column (remainder).
// ----------------------------------------------------------------------------
module spzr_div
    import spzr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [PIXEL_W-1:0] dividend,
    input  logic [WORD_W-1:0]  divisor,
    output logic               busy,
    output logic [PIXEL_W-1:0] quotient,
    output logic [WORD_W-1:0]  remainder
);

    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [PIXEL_W-1:0] quo_reg;
    logic [PIXEL_W-1:0] quo_next;
    logic [WORD_W-1:0]  rem_reg;
    logic [WORD_W-1:0]  rem_next;
    logic [WORD_W-1:0]  dsr_reg;
    logic [WORD_W-1:0]  dsr_next;
    logic [WORD_W:0]    shifted;
    logic [WORD_W:0]    diff;
    logic               fits;

    // Trial subtract of the divisor from the shifted partial remainder
    always_comb
    begin
        shifted = {rem_reg, quo_reg[PIXEL_W-1]};
        diff    = shifted - {1'b0, dsr_reg};
        fits    = (shifted >= {1'b0, dsr_reg});
    end

    // Load on start, then shift in one quotient bit per cycle
    always_comb
    begin
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        if (start)
        begin
            cnt_next = CNT_W'(PIXEL_W);
            quo_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            quo_next = {quo_reg[PIXEL_W-2:0], fits};
            rem_next = fits ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy      = (cnt_reg != '0);
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

`ifndef SYNTHESIS
    a_last_step_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == CNT_W'(1) && !start) |=> !busy)
        else $error("divider still busy after its last step");
`endif

endmodule

FILE: design/spzr_datapath.sv
// ----------------------------------------------------------------------------
// spzr_datapath
// Item capture, zero-run bookkeeping, coordinate divider and the output
// word register.
// ----------------------------------------------------------------------------
module spzr_datapath
    import spzr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  spzr_cmd_t          cmd,
    output spzr_stat_t         stat,
    input  logic [WORD_W-1:0]  line_width,
    input  logic [PIXEL_W-1:0] pixel_number,
    input  logic [WORD_W-1:0]  bin_count,
    input  logic               first_bin,
    input  logic               last_bin,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [WORD_W-1:0]  out_word,
    output logic               last_word
);

    logic [WORD_W-1:0]  zero_run_reg;
    logic [WORD_W-1:0]  zero_run_next;
    logic [WORD_W-1:0]  run_hold_reg;
    logic [WORD_W-1:0]  run_hold_next;
    logic [WORD_W-1:0]  count_reg;
    logic               first_reg;
    logic               last_reg;
    logic               limit_reg;
    logic               limit_next;
    logic [WORD_W-1:0]  run_base;
    logic [WORD_W-1:0]  run_inc;
    logic               count_zero_in;
    logic [WORD_W-1:0]  divisor;
    logic               div_busy;
    logic [PIXEL_W-1:0] quotient;
    logic [WORD_W-1:0]  remainder;
    logic               out_valid_reg;
    logic [WORD_W-1:0]  out_word_reg;
    logic               last_word_reg;
    logic [WORD_W-1:0]  word_mux;

    // Zero line width acts as one
    assign divisor = (line_width == '0) ? WORD_W'(1) : line_width;

    spzr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.capture && first_bin),
        .dividend  (pixel_number),
        .divisor   (divisor),
        .busy      (div_busy),
        .quotient  (quotient),
        .remainder (remainder)
    );

    // Run bookkeeping at capture: a first bin drops the pending run
    always_comb
    begin
        count_zero_in = (bin_count == '0);
        run_base      = first_bin ? '0 : zero_run_reg;
        run_inc       = run_base + 1'b1;
        limit_next    = count_zero_in && (run_inc >= RUN_LIMIT);
        zero_run_next = zero_run_reg;
        run_hold_next = run_hold_reg;
        if (cmd.capture)
        begin
            run_hold_next = limit_next ? RUN_LIMIT : run_base;
            if (last_bin || limit_next || !count_zero_in)
            begin
                zero_run_next = '0;
            end
            else
            begin
                zero_run_next = run_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_run_reg <= '0;
        end
        else
        begin
            zero_run_reg <= zero_run_next;
        end
    end

    // Hold the captured item
    always_ff @(posedge clk)
    begin
        run_hold_reg <= run_hold_next;
        if (cmd.capture)
        begin
            count_reg <= bin_count;
            first_reg <= first_bin;
            last_reg  <= last_bin;
            limit_reg <= limit_next;
        end
    end

    // Select the next output word
    always_comb
    begin
        case (cmd.sel)
            SEL_X_LO:     word_mux = remainder;
            SEL_X_HI:     word_mux = '0;
            SEL_Y_LO:     word_mux = quotient[WORD_W-1:0];
            SEL_Y_HI:     word_mux = WORD_W'(quotient[PIXEL_W-1:WORD_W]);
            SEL_ZERO:     word_mux = '0;
            SEL_FLAG:     word_mux = RUN_FLAG;
            SEL_RUN:      word_mux = run_hold_reg;
            SEL_COUNT:    word_mux = count_reg;
            SEL_END:      word_mux = END_WORD;
            SEL_END_LAST: word_mux = END_WORD;
            default:      word_mux = '0;
        endcase
    end

    // Output register: load on command, drop on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_word_reg  <= word_mux;
            last_word_reg <= (cmd.sel == SEL_END_LAST);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign last_word = last_word_reg;

    // Status toward the controller
    always_comb
    begin
        stat.first      = first_reg;
        stat.last       = last_reg;
        stat.count_zero = (count_reg == '0);
        stat.limit_hit  = limit_reg;
        stat.run_ge3    = (run_hold_reg >= MIN_FLAGGED_RUN);
        stat.run_two    = (run_hold_reg == WORD_W'(2));
        stat.run_one    = (run_hold_reg == WORD_W'(1));
        stat.div_busy   = div_busy;
        stat.out_free   = !out_valid_reg || out_ready;
    end

`ifndef SYNTHESIS
    a_run_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        zero_run_reg < RUN_LIMIT)
        else $error("pending zero run reached the run limit");
`endif

endmodule

FILE: design/spzr_ctrl.sv
// ----------------------------------------------------------------------------
// spzr_ctrl
// Sequencer: accepts one bin, waits for the coordinates when needed, then
// steps through the words of the item one output transfer at a time.
// ----------------------------------------------------------------------------
module spzr_ctrl
    import spzr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  spzr_stat_t stat,
    output spzr_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_DIV,
        S_X_LO,
        S_X_HI,
        S_Y_LO,
        S_Y_HI,
        S_FLAG,
        S_RUN,
        S_ZERO_A,
        S_ZERO_B,
        S_COUNT,
        S_END,
        S_END_LAST
    } state_t;

    state_t state_reg;
    state_t state_next;
    state_t after;
    logic   emit;

    // Close the item: end words on a last bin, else back to idle
    function automatic state_t tail_state(input spzr_stat_t s);
        tail_state = s.last ? S_END : S_IDLE;
    endfunction

    // First body state, entered after the coordinates or straight from dispatch
    function automatic state_t body_state(input spzr_stat_t s);
        state_t nxt;
        if (s.count_zero)
        begin
            nxt = s.limit_hit ? S_FLAG : tail_state(s);
        end
        else if (s.run_ge3)
        begin
            nxt = S_FLAG;
        end
        else if (s.run_two)
        begin
            nxt = S_ZERO_A;
        end
        else if (s.run_one)
        begin
            nxt = S_ZERO_B;
        end
        else
        begin
            nxt = S_COUNT;
        end
        body_state = nxt;
    endfunction

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        after        = S_IDLE;
        emit         = 1'b0;
        cmd.capture  = 1'b0;
        cmd.load_out = 1'b0;
        cmd.sel      = SEL_COUNT;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
                state_next = stat.first ? S_DIV : body_state(stat);
            S_DIV:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_X_LO;
                end
            end
            S_X_LO:
            begin
                emit = 1'b1; cmd.sel = SEL_X_LO; after = S_X_HI;
            end
            S_X_HI:
            begin
                emit = 1'b1; cmd.sel = SEL_X_HI; after = S_Y_LO;
            end
            S_Y_LO:
            begin
                emit = 1'b1; cmd.sel = SEL_Y_LO; after = S_Y_HI;
            end
            S_Y_HI:
            begin
                emit = 1'b1; cmd.sel = SEL_Y_HI; after = body_state(stat);
            end
            S_FLAG:
            begin
                emit = 1'b1; cmd.sel = SEL_FLAG; after = S_RUN;
            end
            S_RUN:
            begin
                emit    = 1'b1;
                cmd.sel = SEL_RUN;
                after   = stat.count_zero ? tail_state(stat) : S_COUNT;
            end
            S_ZERO_A:
            begin
                emit = 1'b1; cmd.sel = SEL_ZERO; after = S_ZERO_B;
            end
            S_ZERO_B:
            begin
                emit = 1'b1; cmd.sel = SEL_ZERO; after = S_COUNT;
            end
            S_COUNT:
            begin
                emit = 1'b1; cmd.sel = SEL_COUNT; after = tail_state(stat);
            end
            S_END:
            begin
                emit = 1'b1; cmd.sel = SEL_END; after = S_END_LAST;
            end
            S_END_LAST:
            begin
                emit = 1'b1; cmd.sel = SEL_END_LAST; after = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase

        // Advance only when the output register can take the word
        if (emit && stat.out_free)
        begin
            cmd.load_out = 1'b1;
            state_next   = after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

`ifndef SYNTHESIS
    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> stat.out_free)
        else $error("output word loaded over a pending word");

    a_capture_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == S_DISPATCH) && !in_ready)
        else $error("capture not followed by dispatch");

    a_no_load_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && stat.div_busy) |=> !$past(cmd.load_out))
        else $error("word emitted while coordinates pending");
`endif

endmodule

FILE: design/spectrum_zero_run_encoder_top.sv
// ----------------------------------------------------------------------------
// spectrum_zero_run_encoder_top
// Zero-run-length encoder for pixel spectra: one histogram bin in, a
// stream of 16-bit words out (coordinates, literal zeros or flagged runs,
// counts and end words).
//
//   port group   dir  handshake          payload
//   bins in      in   in_valid/in_ready  pixel_number, bin_count,
//                                        first_bin, last_bin
//   words out    out  out_valid/out_ready out_word, last_word
//   config       in   APB (psel/penable) paddr, pwdata, prdata
//
// A zero bin that emits nothing goes from idle through dispatch back to idle;
// each emitted word is one sequencer state, left once the sink can take it. A
// first bin also waits for the coordinate divider (one quotient bit per cycle over 24 bits).
// One bin is in flight at a time; in_ready is high only while idle.
// A stalled sink holds the sequencer at the word it is waiting to load.
// Reset (rst_n low) clears the pending zero run and sets line_width to 1.
// ----------------------------------------------------------------------------
module spectrum_zero_run_encoder_top
    import spzr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [PIXEL_W-1:0] pixel_number,
    input  logic [WORD_W-1:0]  bin_count,
    input  logic               first_bin,
    input  logic               last_bin,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [WORD_W-1:0]  out_word,
    output logic               last_word,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    spzr_cmd_t         cmd;
    spzr_stat_t        stat;
    logic              ctrl_ready;
    logic [WORD_W-1:0] line_width_reg;
    logic              cfg_write;

    // Configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_LINE_WIDTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= WORD_W'(1);
        end
        else if (cfg_write)
        begin
            line_width_reg <= pwdata[WORD_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_LINE_WIDTH) ? {16'd0, line_width_reg} : 32'd0;

    spzr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (ctrl_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    spzr_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .line_width   (line_width_reg),
        .pixel_number (pixel_number),
        .bin_count    (bin_count),
        .first_bin    (first_bin),
        .last_bin     (last_bin),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .out_word     (out_word),
        .last_word    (last_word)
    );

    assign in_ready = ctrl_ready;

endmodule
